// ----- design/pile_pkg.sv -----
// Shared types and constants for the position-indexed list engine.
`timescale 1ns / 1ps
`default_nettype none
package pile_pkg;

  localparam int DEFAULT_DEPTH = 32;
  localparam int VALUE_W       = 32;
  localparam int POS_W         = 8;
  localparam int LEN_W         = 11;

  typedef enum logic [2:0] {
    CMD_CLEAR  = 3'd0,
    CMD_APPEND = 3'd1,
    CMD_INSERT = 3'd2,
    CMD_DELETE = 3'd3,
    CMD_GET    = 3'd4,
    CMD_LOCATE = 3'd5,
    CMD_SORT   = 3'd6
  } cmd_t;

  typedef struct packed {
    logic [2:0]                cmd;
    logic [POS_W-1:0]          position;
    logic signed [VALUE_W-1:0] value;
  } in_req_t;

  typedef struct packed {
    logic                      ok;
    logic signed [VALUE_W-1:0] read_value;
    logic [LEN_W-1:0]          found_position;
    logic [LEN_W-1:0]          current_length;
  } out_rsp_t;

  // Per-cycle operation applied by every cell of the row.
  typedef enum logic [2:0] {
    C_HOLD,
    C_INSERT,
    C_DELETE,
    C_ROTATE,
    C_SORT
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    logic     odd_phase;
  } cell_ctl_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_SORT
  } ctrl_state_t;

endpackage
`default_nettype wire

// ----- design/pile_cell.sv -----
// One storage cell of the list row: holds one element and trades with its neighbors.
`timescale 1ns / 1ps
`default_nettype none
module pile_cell #(
  parameter int IDX = 0,
  parameter int IW  = 5,
  parameter int CW  = 6
) (
  input  wire                         clk,
  input  pile_pkg::cell_ctl_t         ctl,
  input  wire  [IW-1:0]               sel_idx,
  input  wire  [CW-1:0]               cnt,
  input  wire  [pile_pkg::VALUE_W-1:0] ins_value,
  input  wire  [pile_pkg::VALUE_W-1:0] prev_data,
  input  wire  [pile_pkg::VALUE_W-1:0] next_data,
  output logic [pile_pkg::VALUE_W-1:0] data
);

  localparam logic [IW-1:0] MY_IDX   = IW'(IDX);
  localparam logic [CW-1:0] MY_CNT   = CW'(IDX);
  localparam logic [CW-1:0] NEXT_CNT = CW'(IDX + 1);
  localparam logic          MY_PAR   = 1'(IDX % 2);
  localparam logic          HAS_PREV = (IDX != 0);

  logic [pile_pkg::VALUE_W-1:0] data_r;
  logic [pile_pkg::VALUE_W-1:0] data_nxt;
  logic                         next_lt_own;
  logic                         own_lt_prev;

  assign next_lt_own = $signed(next_data) < $signed(data_r);
  assign own_lt_prev = $signed(data_r) < $signed(prev_data);

  always_comb begin
    data_nxt = data_r;
    case (ctl.op)
      pile_pkg::C_INSERT: begin
        if (MY_IDX == sel_idx) begin
          data_nxt = ins_value;
        end else if (MY_IDX > sel_idx) begin
          data_nxt = prev_data;
        end
      end
      pile_pkg::C_DELETE: begin
        if (MY_IDX >= sel_idx) begin
          data_nxt = next_data;
        end
      end
      pile_pkg::C_ROTATE: begin
        data_nxt = next_data;
      end
      pile_pkg::C_SORT: begin
        // compare-exchange with the partner chosen by the phase
        if (ctl.odd_phase == MY_PAR) begin
          if (NEXT_CNT < cnt && next_lt_own) begin
            data_nxt = next_data;
          end
        end else begin
          if (HAS_PREV && MY_CNT < cnt && own_lt_prev) begin
            data_nxt = prev_data;
          end
        end
      end
      default: begin
        data_nxt = data_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data = data_r;

endmodule
`default_nettype wire

// ----- design/pile_ctrl.sv -----
// Command sequencer: length count, scan and sort stepping, result register.
`timescale 1ns / 1ps
`default_nettype none
module pile_ctrl #(
  parameter int  DEPTH = pile_pkg::DEFAULT_DEPTH,
  localparam int IW    = $clog2(DEPTH),
  localparam int CW    = $clog2(DEPTH + 1)
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          in_valid,
  output logic                         in_stall,
  input  pile_pkg::in_req_t            in_data,
  output logic                         out_valid,
  input  wire                          out_stall,
  output pile_pkg::out_rsp_t           out_data,
  output pile_pkg::cell_ctl_t          cell_ctl,
  output logic [IW-1:0]                sel_idx,
  output logic [pile_pkg::VALUE_W-1:0] ins_value,
  output logic [CW-1:0]                cnt,
  input  wire  [pile_pkg::VALUE_W-1:0] head_data
);

  localparam int            WW       = ((CW > pile_pkg::POS_W) ? CW : pile_pkg::POS_W) + 1;
  localparam logic [IW-1:0] LAST_STEP = IW'(DEPTH - 1);
  localparam logic [WW-1:0] DEPTH_W   = WW'(DEPTH);

  pile_pkg::ctrl_state_t state_r, state_nxt;
  logic [CW-1:0]                cnt_r, cnt_nxt;
  logic [IW-1:0]                step_r, step_nxt;
  logic [2:0]                   cmd_r, cmd_nxt;
  logic [pile_pkg::VALUE_W-1:0] key_r, key_nxt;
  logic [IW-1:0]                tgt_r, tgt_nxt;
  logic                         hit_r, hit_nxt;
  logic [pile_pkg::VALUE_W-1:0] rd_r, rd_nxt;
  logic [CW-1:0]                fp_r, fp_nxt;
  logic                         out_valid_r;
  pile_pkg::out_rsp_t           out_data_r, rsp_nxt;
  logic                         load_out;

  logic                         accept;
  logic [WW-1:0]                pos_w, cnt_w;
  logic [IW-1:0]                pos_idx;
  logic                         full, pos_ok_del, pos_ok_ins, last_step;

  assign in_stall   = (state_r != pile_pkg::S_IDLE) || (out_valid_r && out_stall);
  assign accept     = in_valid && !in_stall;
  assign pos_w      = WW'(in_data.position);
  assign cnt_w      = WW'(cnt_r);
  assign pos_idx    = IW'(pos_w - WW'(1));
  assign full       = (cnt_w >= DEPTH_W);
  assign pos_ok_del = (pos_w != '0) && (pos_w <= cnt_w);
  assign pos_ok_ins = !full && (pos_w != '0) && (pos_w <= cnt_w + WW'(1));
  assign last_step  = (step_r == LAST_STEP);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      pile_pkg::S_IDLE: begin
        if (accept) begin
          case (in_data.cmd)
            pile_pkg::CMD_GET: begin
              if (pos_ok_del) state_nxt = pile_pkg::S_SCAN;
            end
            pile_pkg::CMD_LOCATE: begin
              if (cnt_r != '0) state_nxt = pile_pkg::S_SCAN;
            end
            pile_pkg::CMD_SORT: begin
              state_nxt = pile_pkg::S_SORT;
            end
            default: begin
              state_nxt = pile_pkg::S_IDLE;
            end
          endcase
        end
      end
      pile_pkg::S_SCAN, pile_pkg::S_SORT: begin
        if (last_step) state_nxt = pile_pkg::S_IDLE;
      end
      default: begin
        state_nxt = pile_pkg::S_IDLE;
      end
    endcase
  end

  // outputs and datapath
  always_comb begin
    cell_ctl.op        = pile_pkg::C_HOLD;
    cell_ctl.odd_phase = step_r[0];
    sel_idx            = pos_idx;
    ins_value          = in_data.value;
    cnt_nxt            = cnt_r;
    step_nxt           = step_r;
    cmd_nxt            = cmd_r;
    key_nxt            = key_r;
    tgt_nxt            = tgt_r;
    hit_nxt            = hit_r;
    rd_nxt             = rd_r;
    fp_nxt             = fp_r;
    load_out           = 1'b0;
    rsp_nxt.ok         = 1'b0;
    rsp_nxt.read_value = '0;
    rsp_nxt.found_position = '0;
    case (state_r)
      pile_pkg::S_IDLE: begin
        if (accept) begin
          step_nxt = '0;
          cmd_nxt  = in_data.cmd;
          key_nxt  = in_data.value;
          tgt_nxt  = pos_idx;
          hit_nxt  = 1'b0;
          rd_nxt   = '0;
          fp_nxt   = '0;
          case (in_data.cmd)
            pile_pkg::CMD_CLEAR: begin
              cnt_nxt    = '0;
              rsp_nxt.ok = 1'b1;
              load_out   = 1'b1;
            end
            pile_pkg::CMD_APPEND: begin
              load_out = 1'b1;
              if (!full) begin
                cell_ctl.op = pile_pkg::C_INSERT;
                sel_idx     = IW'(cnt_r);
                cnt_nxt     = cnt_r + CW'(1);
                rsp_nxt.ok  = 1'b1;
              end
            end
            pile_pkg::CMD_INSERT: begin
              load_out = 1'b1;
              if (pos_ok_ins) begin
                cell_ctl.op = pile_pkg::C_INSERT;
                cnt_nxt     = cnt_r + CW'(1);
                rsp_nxt.ok  = 1'b1;
              end
            end
            pile_pkg::CMD_DELETE: begin
              load_out = 1'b1;
              if (pos_ok_del) begin
                cell_ctl.op = pile_pkg::C_DELETE;
                cnt_nxt     = cnt_r - CW'(1);
                rsp_nxt.ok  = 1'b1;
              end
            end
            pile_pkg::CMD_GET: begin
              if (!pos_ok_del) load_out = 1'b1;
            end
            pile_pkg::CMD_LOCATE: begin
              if (cnt_r == '0) load_out = 1'b1;
            end
            pile_pkg::CMD_SORT: begin
              load_out = 1'b0;
            end
            default: begin
              load_out = 1'b1;
            end
          endcase
        end
      end
      pile_pkg::S_SCAN: begin
        // rotate the row so each element passes the head cell once
        cell_ctl.op = pile_pkg::C_ROTATE;
        step_nxt    = step_r + IW'(1);
        if (cmd_r == pile_pkg::CMD_GET && step_r == tgt_r) begin
          rd_nxt  = head_data;
          hit_nxt = 1'b1;
        end
        if (cmd_r == pile_pkg::CMD_LOCATE && !hit_r && CW'(step_r) < cnt_r &&
            head_data == key_r) begin
          hit_nxt = 1'b1;
          fp_nxt  = CW'(step_r) + CW'(1);
        end
        if (last_step) begin
          load_out               = 1'b1;
          rsp_nxt.ok             = hit_nxt;
          rsp_nxt.read_value     = rd_nxt;
          rsp_nxt.found_position = pile_pkg::LEN_W'(fp_nxt);
        end
      end
      pile_pkg::S_SORT: begin
        cell_ctl.op = pile_pkg::C_SORT;
        step_nxt    = step_r + IW'(1);
        if (last_step) begin
          load_out   = 1'b1;
          rsp_nxt.ok = 1'b1;
        end
      end
      default: begin
        cell_ctl.op = pile_pkg::C_HOLD;
      end
    endcase
    rsp_nxt.current_length = pile_pkg::LEN_W'(cnt_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pile_pkg::S_IDLE;
      cnt_r       <= '0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      step_r  <= step_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
    key_r <= key_nxt;
    tgt_r <= tgt_nxt;
    hit_r <= hit_nxt;
    rd_r  <= rd_nxt;
    fp_r  <= fp_nxt;
    if (load_out) begin
      out_data_r <= rsp_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign cnt       = cnt_r;

  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DEPTH))
    else $error("list length above depth");

  a_busy_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != pile_pkg::S_IDLE) |-> in_stall)
    else $error("request taken while a scan or sort runs");

  a_finish_loads: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == pile_pkg::S_SCAN || state_r == pile_pkg::S_SORT) && last_step)
    |=> (out_valid_r && state_r == pile_pkg::S_IDLE))
    else $error("scan or sort ended without a result");

  a_rotate_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (cell_ctl.op == pile_pkg::C_ROTATE) |-> (state_r == pile_pkg::S_SCAN))
    else $error("row rotated outside a scan");

  a_len_stable_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != pile_pkg::S_IDLE) |=> $stable(cnt_r))
    else $error("length changed during a scan or sort");

endmodule
`default_nettype wire

// ----- design/position_indexed_list_engine_unit.sv -----
// Top level of the position-indexed list engine: sequencer plus a row of element cells.
// Responses: clear, append, insert, delete, an out-of-range get, a locate on an empty list and
//   the unused code load the result register at acceptance; other gets and locates rotate the
//   row past the head cell and sort runs DEPTH odd-even passes, answering when they finish.
// Flow: requests go back to back but stall during a scan or sort and while a response is held.
// Reset (synchronous, rst_n low): length to zero, sequencer idle, cells undefined until written.
`timescale 1ns / 1ps
`default_nettype none
module position_indexed_list_engine_unit #(
  parameter int DEPTH = pile_pkg::DEFAULT_DEPTH
) (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                in_valid,
  output logic               in_stall,
  input  pile_pkg::in_req_t  in_data,
  output logic               out_valid,
  input  wire                out_stall,
  output pile_pkg::out_rsp_t out_data
);

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  // Control broadcast to every cell. Each cell compares its own fixed index against
  // sel_idx (insert/delete) and against the length (sort), so no position decode is
  // shared and the row scales with DEPTH.
  pile_pkg::cell_ctl_t          cell_ctl;
  logic [IW-1:0]                sel_idx;
  logic [pile_pkg::VALUE_W-1:0] ins_value;
  logic [CW-1:0]                cnt;

  // cell_data[i] is the element at 0-based position i.
  logic [pile_pkg::VALUE_W-1:0] cell_data [DEPTH];

  pile_ctrl #(
    .DEPTH(DEPTH)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cell_ctl (cell_ctl),
    .sel_idx  (sel_idx),
    .ins_value(ins_value),
    .cnt      (cnt),
    .head_data(cell_data[0])
  );

  // The row closes into a ring: the last cell's right neighbor is cell 0, so a rotate
  // walks every element past the head and returns the list to place after one full turn.
  // Values shifted into slots past the length are don't-care and never observed.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    localparam int PREV = (i == 0) ? DEPTH - 1 : i - 1;
    localparam int NEXT = (i == DEPTH - 1) ? 0 : i + 1;

    pile_cell #(
      .IDX(i),
      .IW (IW),
      .CW (CW)
    ) u_cell (
      .clk      (clk),
      .ctl      (cell_ctl),
      .sel_idx  (sel_idx),
      .cnt      (cnt),
      .ins_value(ins_value),
      .prev_data(cell_data[PREV]),
      .next_data(cell_data[NEXT]),
      .data     (cell_data[i])
    );
  end

endmodule
`default_nettype wire

// ----- tb/pile_list_checker.sv -----
// Channel monitor, list predictor and response scoreboard for the list engine.
`timescale 1ns / 1ps
module pile_list_checker #(
  parameter int DEPTH = pile_pkg::DEFAULT_DEPTH
) (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                in_valid,
  input  wire                in_stall,
  input  pile_pkg::in_req_t  in_data,
  input  wire                out_valid,
  input  wire                out_stall,
  input  pile_pkg::out_rsp_t out_data,
  output int                 mismatch_count,
  output int                 rsp_due
);
  import pile_pkg::*;

  localparam int PRINT_CAP = 40;

  logic signed [VALUE_W-1:0] list_cells [DEPTH];
  int                        list_len;

  out_rsp_t rsp_due_q [$];
  in_req_t  req_log_q [$];

  initial begin
    mismatch_count = 0;
    rsp_due        = 0;
    list_len       = 0;
  end

  // Apply one request to the shadow list and return the response it should give.
  function automatic out_rsp_t list_apply(input in_req_t req);
    out_rsp_t                  r;
    int                        p;
    int                        i;
    int                        j;
    logic signed [VALUE_W-1:0] key;
    r = '0;
    p = int'(req.position);
    case (req.cmd)
      CMD_CLEAR: begin
        list_len = 0;
        r.ok     = 1'b1;
      end
      CMD_APPEND: begin
        if (list_len < DEPTH) begin
          list_cells[list_len] = req.value;
          list_len++;
          r.ok = 1'b1;
        end
      end
      CMD_INSERT: begin
        if (list_len < DEPTH && p >= 1 && p <= list_len + 1) begin
          for (i = list_len; i > p - 1; i--) list_cells[i] = list_cells[i-1];
          list_cells[p-1] = req.value;
          list_len++;
          r.ok = 1'b1;
        end
      end
      CMD_DELETE: begin
        if (p >= 1 && p <= list_len) begin
          for (i = p - 1; i + 1 < list_len; i++) list_cells[i] = list_cells[i+1];
          list_len--;
          r.ok = 1'b1;
        end
      end
      CMD_GET: begin
        if (p >= 1 && p <= list_len) begin
          r.read_value = list_cells[p-1];
          r.ok         = 1'b1;
        end
      end
      CMD_LOCATE: begin
        for (i = 0; i < list_len; i++) begin
          if (list_cells[i] == req.value) begin
            r.found_position = LEN_W'(i + 1);
            r.ok             = 1'b1;
            break;
          end
        end
      end
      CMD_SORT: begin
        // ascending signed order, stable
        for (i = 1; i < list_len; i++) begin
          key = list_cells[i];
          j   = i;
          while (j > 0 && key < list_cells[j-1]) begin
            list_cells[j] = list_cells[j-1];
            j--;
          end
          list_cells[j] = key;
        end
        r.ok = 1'b1;
      end
      default: ;
    endcase
    r.current_length = LEN_W'(list_len);
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    if (mismatch_count < PRINT_CAP) $display("[%0t] list check: %s", $time, what);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    out_rsp_t want;
    in_req_t  req;
    if (!rst_n) begin
      rsp_due_q.delete();
      req_log_q.delete();
      list_len = 0;
    end else begin
      // retire the response first: it can never belong to a request taken at this edge
      if (out_valid && !out_stall) begin
        if (rsp_due_q.size() == 0) begin
          report_mismatch($sformatf("response with none pending: %p", out_data));
        end else begin
          want = rsp_due_q.pop_front();
          req  = req_log_q.pop_front();
          if (out_data.ok !== want.ok)
            report_mismatch($sformatf("ok %b, want %b for %p",
                                      out_data.ok, want.ok, req));
          if (out_data.read_value !== want.read_value)
            report_mismatch($sformatf("read_value %0d, want %0d for %p",
                                      out_data.read_value, want.read_value, req));
          if (out_data.found_position !== want.found_position)
            report_mismatch($sformatf("found_position %0d, want %0d for %p",
                                      out_data.found_position, want.found_position, req));
          if (out_data.current_length !== want.current_length)
            report_mismatch($sformatf("current_length %0d, want %0d for %p",
                                      out_data.current_length, want.current_length, req));
        end
      end
      if (in_valid && !in_stall) begin
        rsp_due_q.push_back(list_apply(in_data));
        req_log_q.push_back(in_data);
      end
    end
    rsp_due = rsp_due_q.size();
  end

endmodule

// ----- tb/tb_position_indexed_list_engine_unit.sv -----
// Testbench top for the list engine: clock, reset, request stimulus, receiver stalls, verdict.
`timescale 1ns / 1ps
module tb_position_indexed_list_engine_unit;
  import pile_pkg::*;

  localparam int DEPTH        = DEFAULT_DEPTH;
  // Longest a correct run may go with no handshake on either channel: a full
  // receiver hold-off plus a sort and a long sender gap, taken several times over.
  localparam int QUIET_LIMIT  = 2000;
  localparam int HOLD_CYCLES  = 300;
  localparam int RAND_BLOCKS  = 8;
  localparam int BLOCK_ITEMS  = 120;
  // Command code that the engine leaves unused.
  localparam logic [2:0] CMD_SPARE = 3'd7;

  localparam logic signed [VALUE_W-1:0] VAL_MIN = 32'h8000_0000;
  localparam logic signed [VALUE_W-1:0] VAL_MAX = 32'h7FFF_FFFF;

  // Idle mix per random block: none, sender idle, receiver stall, both lightly.
  localparam int SEND_IDLE_PCT [4] = '{0, 60, 0, 11};
  localparam int STALL_PCT     [4] = '{0, 0, 60, 11};

  // Command mix of a random block: fill the list, drain it, or keep it level.
  typedef enum int {MIX_GROW, MIX_SHRINK, MIX_LEVEL} mix_t;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_stall;
  in_req_t  in_data;
  logic     out_valid;
  logic     out_stall;
  out_rsp_t out_data;

  int mismatch_count;
  int rsp_due;
  int send_idle_pct;
  int stall_pct;
  int hold_asked;
  int hold_served;
  int quiet_cycles;

  position_indexed_list_engine_unit #(.DEPTH(DEPTH)) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  pile_list_checker #(.DEPTH(DEPTH)) u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_data      (out_data),
    .mismatch_count(mismatch_count),
    .rsp_due       (rsp_due)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Pack one request.
  function automatic in_req_t make_request(input logic [2:0] cmd, input int pos,
                                           input logic signed [VALUE_W-1:0] val);
    in_req_t r;
    r.cmd      = cmd;
    r.position = POS_W'(pos);
    r.value    = val;
    return r;
  endfunction

  // Favor small positions so get, delete and insert mostly land inside the list,
  // but keep the whole 8-bit range in play.
  function automatic int rand_position();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 45) return $urandom_range(0, 8);
    if (pick < 85) return $urandom_range(0, DEPTH + 2);
    return $urandom_range(0, 255);
  endfunction

  // Draw values from a tiny pool often enough that locate hits and sort sees duplicates.
  function automatic logic signed [VALUE_W-1:0] rand_value();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 40) return $urandom_range(0, 7) - 3;
    if (pick < 50) begin
      case ($urandom_range(0, 3))
        0:       return VAL_MIN;
        1:       return VAL_MAX;
        2:       return '0;
        default: return '1;
      endcase
    end
    return $urandom();
  endfunction

  function automatic in_req_t rand_request(input mix_t mix);
    in_req_t     r;
    int unsigned pick;
    int unsigned w_clr;
    int unsigned w_add;
    int unsigned w_del;
    case (mix)
      MIX_GROW:   begin w_clr = 0; w_add = 30; w_del = 8;  end
      MIX_SHRINK: begin w_clr = 3; w_add = 8;  w_del = 45; end
      default:    begin w_clr = 2; w_add = 18; w_del = 22; end
    endcase
    r.position = POS_W'(rand_position());
    r.value    = rand_value();
    pick       = $urandom_range(0, 99);
    if (pick < 1)                                 r.cmd = CMD_SPARE;
    else if (pick < 1 + w_clr)                    r.cmd = CMD_CLEAR;
    else if (pick < 6 + w_clr)                    r.cmd = CMD_SORT;
    else if (pick < 6 + w_clr + w_add)            r.cmd = CMD_APPEND;
    else if (pick < 6 + w_clr + 2 * w_add)        r.cmd = CMD_INSERT;
    else if (pick < 6 + w_clr + 2 * w_add + w_del) r.cmd = CMD_DELETE;
    else r.cmd = ($urandom_range(0, 1) == 0) ? CMD_GET : CMD_LOCATE;
    return r;
  endfunction

  // Offer one request and hold it until the engine takes it. Called at a falling
  // edge and returns at a falling edge. Valid is only lowered for an idle gap, so
  // back-to-back requests never see valid dropped and raised in one step.
  task automatic send_request(input in_req_t req);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // Receiver: random stalls at the rate the current phase asks, plus a long
  // hold-off on request, counted here so the sender keeps offering meanwhile.
  initial begin
    int hold_left;
    hold_left   = 0;
    hold_served = 0;
    out_stall   = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_asked != hold_served) begin
        hold_served = hold_asked;
        hold_left   = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  // Watchdog: end the run if neither channel moves for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int blk;
    int n;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_data       = '0;
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_asked    = 0;
    quiet_cycles  = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: empty-list failures, extreme values, edge positions, every command.
    send_request(make_request(CMD_CLEAR,  0, '0));
    send_request(make_request(CMD_GET,    1, '0));        // get on empty list
    send_request(make_request(CMD_DELETE, 1, '0));        // delete on empty list
    send_request(make_request(CMD_LOCATE, 0, '0));        // locate on empty list
    send_request(make_request(CMD_SORT,   0, '0));        // sort empty list
    send_request(make_request(CMD_APPEND, 0, VAL_MIN));
    send_request(make_request(CMD_APPEND, 0, VAL_MAX));
    send_request(make_request(CMD_INSERT, 0, 9));         // position zero
    send_request(make_request(CMD_INSERT, 4, 9));         // past length + 1
    send_request(make_request(CMD_INSERT, 1, -1));        // at the head
    send_request(make_request(CMD_INSERT, 4, 0));         // at length + 1
    send_request(make_request(CMD_GET,    4, '0));        // tail
    send_request(make_request(CMD_GET,    5, '0));        // one past the tail
    send_request(make_request(CMD_GET,    255, '0));      // top of the position range
    send_request(make_request(CMD_LOCATE, 0, VAL_MAX));
    send_request(make_request(CMD_LOCATE, 0, 12345));     // absent value
    send_request(make_request(CMD_SORT,   0, '0));        // mixed signs
    send_request(make_request(CMD_GET,    1, '0));
    send_request(make_request(CMD_DELETE, 4, '0));        // tail
    send_request(make_request(CMD_DELETE, 0, '0));        // position zero
    send_request(make_request(CMD_DELETE, 1, '0));        // head
    send_request(make_request(CMD_SPARE,  1, 7));         // unused command code
    send_request(make_request(CMD_CLEAR,  0, '0));
    send_request(make_request(CMD_APPEND, 0, 5));
    send_request(make_request(CMD_SORT,   0, '0));        // single element

    // Random: rotate idle phases and command mixes; fill blocks drive the list
    // to full so append and insert hit the capacity limit.
    for (blk = 0; blk < RAND_BLOCKS; blk++) begin
      send_idle_pct = SEND_IDLE_PCT[blk % 4];
      stall_pct     = STALL_PCT[blk % 4];
      for (n = 0; n < BLOCK_ITEMS; n++) begin
        // In the no-idle phases, hold off the receiver mid-block while requests
        // keep coming, so the engine backs up and stalls its input.
        if ((blk % 4) == 0 && n == BLOCK_ITEMS / 2) hold_asked++;
        send_request(rand_request(mix_t'(blk % 3)));
      end
    end
    in_valid <= 1'b0;

    // Drain, then allow a full sort's worth of cycles for any stray response.
    while (rsp_due != 0) @(negedge clk);
    repeat (DEPTH + 4) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
design/pile_pkg.sv
design/pile_cell.sv
design/pile_ctrl.sv
design/position_indexed_list_engine_unit.sv
tb/pile_list_checker.sv
tb/tb_position_indexed_list_engine_unit.sv
